>>> hdl/gaussian_blur_3x3_rgb_defines.svh
// Assertion macros for the checker file of the blur block.
`ifndef GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_RGB_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define GB3_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gb3 assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define GB3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gb3 assertion failed");

`endif

>>> hdl/gb3_pkg.sv
// Types, constants and the tap rounding function of the 3x3 blur.
`timescale 1ns / 1ps

package gb3_pkg;

	localparam int PIX_W       = 8;
	localparam int CFG_W       = 12;
	localparam int TAP_W       = 7;
	localparam int SUM_W       = 11;
	localparam int WIDTH_RESET = 640;
	localparam int WIDTH_MIN   = 3;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W       = FIFO_CNT_W + 1;

	// Row tracking only needs to know whether two full rows have passed.
	localparam logic [1:0] ROW_FIRST  = 2'd0;
	localparam logic [1:0] ROW_SECOND = 2'd1;
	localparam logic [1:0] ROW_FULL   = 2'd2;

	localparam logic [2:0] TAP_WEIGHT [3][3] = '{
		'{3'd1, 3'd2, 3'd1},
		'{3'd2, 3'd4, 3'd2},
		'{3'd1, 3'd2, 3'd1}
	};

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t upper;
		pixel_t lower;
	} line_pair_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic row_end;
	} gb3_ctrl_t;

	typedef struct packed {
		pixel_t px;
		logic   row_end;
	} result_t;

	// x/16 rounded to nearest with ties to even.
	function automatic logic [TAP_W-1:0] div16_even(input logic [9:0] x);
		logic [5:0] q;
		logic [3:0] r;
		logic       up;
		q  = x[9:4];
		r  = x[3:0];
		up = (r > 4'd8) || ((r == 4'd8) && q[0]);
		return TAP_W'(q) + TAP_W'(up);
	endfunction

endpackage

>>> hdl/gaussian_blur_3x3_rgb.sv
// Top level of the 3x3 Gaussian blur for a 24-bit RGB raster pixel stream.
`timescale 1ns / 1ps
// Path: stage one, window and tap registers, then the output queue; shown when the output is free.
// Throughput: one request per clock while in_stall is low; the line store memory does one read and one write per cycle.
// The input stalls only when eight requests are in flight or queued, so a slow sink backs up.
// Reset: arst_n clears counters, window, pipeline valids and queue; width to min(640, MAX_WIDTH).
// The line store memory is not cleared and needs no clearing pass.

module gaussian_blur_3x3_rgb import gb3_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       blue_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       red_in,
	input  logic             frame_start,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       blue_out,
	output logic [7:0]       green_out,
	output logic [7:0]       red_out,
	output logic             row_end
);

	// Column addresses span the deepest row; the width compare is wide enough
	// for both the register field and MAX_WIDTH itself.
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W       = (WIDTH_W > CFG_W) ? WIDTH_W : CFG_W;
	localparam int RESET_WIDTH = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

	logic [CMP_W-1:0] width_q;
	logic [CMP_W-1:0] cfg_ext;
	logic [COL_W-1:0] col_q;
	logic [1:0]       row_q;
	logic [COL_W-1:0] col_cur;
	logic [1:0]       row_cur;
	logic [CMP_W-1:0] col_plus1;
	logic             last_col;
	logic             accept;

	logic             s1_valid_q;
	pixel_t           pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             emit_s1;
	logic             row_end_s1;

	pixel_t           pix_in;
	line_pair_t       rd_pair;
	line_pair_t       wr_pair;
	gb3_ctrl_t        filt_ctrl;
	logic             res_valid;
	result_t          res;
	logic [1:0]       filt_cnt;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [OCC_W-1:0] occupancy;
	logic             pop;
	result_t          head;

	function automatic logic [1:0] row_step(input logic [1:0] row);
		return (row == ROW_FULL) ? ROW_FULL : row + 2'd1;
	endfunction

	// The width register holds the already clamped width, so the pixel path
	// never sees a value outside 3 to MAX_WIDTH.
	assign cfg_ready = 1'b1;
	assign cfg_ext   = CMP_W'(cfg_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CMP_W'(RESET_WIDTH);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_ext < CMP_W'(WIDTH_MIN)) begin
				width_q <= CMP_W'(WIDTH_MIN);
			end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
				width_q <= CMP_W'(MAX_WIDTH);
			end else begin
				width_q <= cfg_ext;
			end
		end
	end

	// Position of the incoming pixel. A frame start forces the origin; a column
	// that is past the current width (the width shrank mid-row) wraps to a new row.
	always_comb begin
		if (frame_start) begin
			col_cur = '0;
			row_cur = ROW_FIRST;
		end else if (CMP_W'(col_q) >= width_q) begin
			col_cur = '0;
			row_cur = row_step(row_q);
		end else begin
			col_cur = col_q;
			row_cur = row_q;
		end
		col_plus1 = CMP_W'(col_cur) + CMP_W'(1);
		last_col  = (col_plus1 >= width_q);
	end

	// Every request in the pipeline or the queue holds a queue slot, so the
	// pipeline never has to stop once a request is taken.
	assign occupancy = OCC_W'(s1_valid_q) + OCC_W'(filt_cnt) + OCC_W'(fifo_cnt);
	assign in_stall  = (occupancy >= OCC_W'(FIFO_DEPTH));
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= ROW_FIRST;
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= row_step(row_cur);
				end else begin
					col_q <= col_plus1[COL_W-1:0];
					row_q <= row_cur;
				end
			end
		end
	end

	assign pix_in = '{red: red_in, green: green_in, blue: blue_in};

	// Stage one payload: the pixel, its column and whether it closes a full window.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pix_in;
			col_s1     <= col_cur;
			emit_s1    <= (row_cur == ROW_FULL) && (col_cur >= COL_W'(2));
			row_end_s1 <= last_col;
		end
	end

	// Read the two rows above at acceptance; in the next cycle the row shifts up
	// and the new pixel goes in at the same column. Back-to-back requests on the
	// same column are covered by the bypass inside the memory.
	assign wr_pair = '{upper: rd_pair.lower, lower: pix_s1};

	gb3_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (COL_W)
	) u_line_mem (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_cur),
		.rd_data (rd_pair),
		.wr_en   (s1_valid_q),
		.wr_addr (col_s1),
		.wr_data (wr_pair)
	);

	assign filt_ctrl = '{valid: s1_valid_q, emit: emit_s1, row_end: row_end_s1};

	gb3_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_in   (filt_ctrl),
		.col_top   (rd_pair.upper),
		.col_mid   (rd_pair.lower),
		.col_bot   (pix_s1),
		.res_valid (res_valid),
		.res       (res),
		.pipe_cnt  (filt_cnt)
	);

	// Results wait here, so a stalled sink never blocks the line store updates.
	assign pop = out_valid && !out_stall;

	gb3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign red_out   = head.px.red;
	assign green_out = head.px.green;
	assign blue_out  = head.px.blue;
	assign row_end   = head.row_end;

endmodule

>>> hdl/gb3_line_mem.sv
// Line store memory holding the two previous rows, with write-to-read bypass.
`timescale 1ns / 1ps

module gb3_line_mem import gb3_pkg::*; #(
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output line_pair_t        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  line_pair_t        wr_data
);

	line_pair_t mem [DEPTH];
	line_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A read of the entry being written in the same cycle returns the new data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/gb3_filter.sv
// Sliding 3x3 window, rounded weighted taps and per-channel saturating sum.
`timescale 1ns / 1ps

module gb3_filter import gb3_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  gb3_ctrl_t  ctrl_in,
	input  pixel_t     col_top,
	input  pixel_t     col_mid,
	input  pixel_t     col_bot,
	output logic       res_valid,
	output result_t    res,
	output logic [1:0] pipe_cnt
);

	pixel_t          win_q [3][3];
	gb3_ctrl_t       ctrl_s2;
	gb3_ctrl_t       ctrl_s3;
	logic [TAP_W-1:0] tap_red   [9];
	logic [TAP_W-1:0] tap_green [9];
	logic [TAP_W-1:0] tap_blue  [9];
	logic [TAP_W-1:0] red_s3    [9];
	logic [TAP_W-1:0] green_s3  [9];
	logic [TAP_W-1:0] blue_s3   [9];
	logic [SUM_W-1:0] sum_red;
	logic [SUM_W-1:0] sum_green;
	logic [SUM_W-1:0] sum_blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (ctrl_in.valid) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_top;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_bot;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				tap_red[r*3+c]   = div16_even(10'(win_q[r][c].red) * 10'(TAP_WEIGHT[r][c]));
				tap_green[r*3+c] = div16_even(10'(win_q[r][c].green) * 10'(TAP_WEIGHT[r][c]));
				tap_blue[r*3+c]  = div16_even(10'(win_q[r][c].blue) * 10'(TAP_WEIGHT[r][c]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s2 <= ctrl_in;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.valid) begin
			red_s3   <= tap_red;
			green_s3 <= tap_green;
			blue_s3  <= tap_blue;
		end
	end

	always_comb begin
		sum_red   = '0;
		sum_green = '0;
		sum_blue  = '0;
		for (int k = 0; k < 9; k++) begin
			sum_red   = sum_red + SUM_W'(red_s3[k]);
			sum_green = sum_green + SUM_W'(green_s3[k]);
			sum_blue  = sum_blue + SUM_W'(blue_s3[k]);
		end
		res.px.red   = (sum_red > SUM_W'(255)) ? 8'hFF : sum_red[PIX_W-1:0];
		res.px.green = (sum_green > SUM_W'(255)) ? 8'hFF : sum_green[PIX_W-1:0];
		res.px.blue  = (sum_blue > SUM_W'(255)) ? 8'hFF : sum_blue[PIX_W-1:0];
		res.row_end  = ctrl_s3.row_end;
	end

	assign res_valid = ctrl_s3.valid && ctrl_s3.emit;
	assign pipe_cnt  = 2'(ctrl_s2.valid) + 2'(ctrl_s3.valid);

endmodule

>>> hdl/gb3_out_fifo.sv
// Small output queue that decouples the filter pipeline from result stalls.
`timescale 1ns / 1ps

module gb3_out_fifo import gb3_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  result_t               push_data,
	input  logic                  pop,
	output logic                  not_empty,
	output result_t               head,
	output logic [FIFO_CNT_W-1:0] count
);

	result_t               entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign count     = count_q;

endmodule

>>> hdl/gb3_checker.sv
// Port-level checker for the blur block and its bind to the top level.
`timescale 1ns / 1ps
`include "gaussian_blur_3x3_rgb_defines.svh"

module gb3_checker import gb3_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] blue_out,
	input logic [7:0] green_out,
	input logic [7:0] red_out,
	input logic       row_end
);

	// A full window needs at least three rows of three pixels.
	localparam int MIN_FOR_OUT = 9;
	localparam int CNT_CAP     = (FIFO_DEPTH > MIN_FOR_OUT) ? FIFO_DEPTH : MIN_FOR_OUT;
	localparam int CNT_W       = $clog2(CNT_CAP + 1);

	logic [CNT_W-1:0] in_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q <= '0;
		end else if (in_valid && !in_stall && (in_cnt_q != CNT_W'(CNT_CAP))) begin
			in_cnt_q <= in_cnt_q + 1'b1;
		end
	end

	`GB3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`GB3_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(row_end))
	`GB3_ASSERT_IMPL(a_out_needs_window, out_valid, in_cnt_q >= CNT_W'(MIN_FOR_OUT))
	`GB3_ASSERT_IMPL(a_stall_needs_backlog, in_stall, in_cnt_q >= CNT_W'(FIFO_DEPTH))

endmodule

bind gaussian_blur_3x3_rgb gb3_checker u_gb3_checker (.*);
